// ===== rtl/two_bit_strobe_bus_master_macros.svh =====
// ----------------------------------------------------------------------------
// two-bit strobe bus master assertion macros
// shared assertion forms for the checker
// ----------------------------------------------------------------------------
`ifndef TWO_BIT_STROBE_BUS_MASTER_MACROS_SVH
`define TWO_BIT_STROBE_BUS_MASTER_MACROS_SVH

// clocked assertion, off while reset is asserted
`define TBSB_ASSERT(lbl, clk_s, rstn_s, prop, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) else $error(msg);

// clocked assertion that also holds during reset
`define TBSB_ASSERT_ALWAYS(lbl, clk_s, prop, msg) \
	lbl: assert property (@(posedge clk_s) prop) else $error(msg);

`endif

// ===== rtl/tbsb_pkg.sv =====
// ----------------------------------------------------------------------------
// tbsb_pkg
// types, codes and the phase pin function of the strobe bus master
// ----------------------------------------------------------------------------
package tbsb_pkg;

	// pin_levels bit positions
	localparam logic [3:0] PIN_HIGH = 4'h8;
	localparam logic [3:0] PIN_LOW  = 4'h4;
	localparam logic [3:0] PIN_STB0 = 4'h2;
	localparam logic [3:0] PIN_STB1 = 4'h1;

	// operation codes
	localparam logic [1:0] OP_READ     = 2'd0;
	localparam logic [1:0] OP_WRITE    = 2'd1;
	localparam logic [1:0] OP_KICK     = 2'd2;
	localparam logic [1:0] OP_RESERVED = 2'd3;

	// phase codes
	localparam logic [2:0] PH_STROBES_UP = 3'd0;
	localparam logic [2:0] PH_ADDR_HIGH  = 3'd1;
	localparam logic [2:0] PH_ADDR_LOW   = 3'd2;
	localparam logic [2:0] PH_SLOT       = 3'd3;
	localparam logic [2:0] PH_DATA       = 3'd4;
	localparam logic [2:0] PH_RELEASE    = 3'd5;

	localparam logic [1:0] SLOT_FIRST = 2'd0;
	localparam logic [1:0] SLOT_LAST  = 2'd3;

	// configuration register indexes
	localparam logic [0:0] CFG_PHASE_LENGTH    = 1'b0;
	localparam logic [0:0] CFG_CONTROL_ADDRESS = 1'b1;

	typedef struct packed {
		logic       line_high;
		logic       line_low;
		logic       strobe_zero;
		logic       strobe_one;
		logic       busy_res;
		logic       done_res;
		logic [7:0] read_data;
	} res_t;

	// pin levels on entry to a phase
	function automatic logic [3:0] enter_pins(
		input logic [2:0] phase,
		input logic [1:0] op,
		input logic [1:0] slot,
		input logic [3:0] addr,
		input logic [7:0] data,
		input logic [3:0] pins
	);
		logic [1:0] sel;
		logic [1:0] dat;
		logic [3:0] p;
		if (op == OP_KICK) begin
			sel = {1'b1, data[1]};
			dat = data[0] ? 2'd2 : 2'd1;
		end else begin
			sel = slot;
			dat = data[{slot, 1'b0} +: 2];
		end
		p = pins;
		case (phase)
			PH_STROBES_UP: p = p | PIN_STB0 | PIN_STB1;
			PH_ADDR_HIGH:  p = {addr[3:2], 2'b00};
			PH_ADDR_LOW:   p = {addr[1:0], 1'b1, p[0]};
			PH_SLOT:       p = {sel, 1'b0, p[0]};
			PH_DATA:       p = {dat, p[1], 1'b1};
			default:       p = p & ~PIN_STB1;
		endcase
		return p;
	endfunction

endpackage

// ===== rtl/tbsb_core.sv =====
// ----------------------------------------------------------------------------
// tbsb_core
// slot and phase sequencer state with its next-state logic
// ----------------------------------------------------------------------------
module tbsb_core
	import tbsb_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic       start_req,
	input  logic [1:0] func,
	input  logic [3:0] address,
	input  logic [7:0] write_data,
	input  logic [1:0] segment,
	input  logic       return_high,
	input  logic       return_low,
	input  logic       cfg_we,
	input  logic [0:0] cfg_index,
	input  logic [7:0] cfg_data,
	output res_t       res
);

	logic [7:0] plen_q;
	logic [3:0] ctl_q;
	logic [2:0] phase_q, n_phase;
	logic [1:0] slot_q, n_slot;
	logic [7:0] tick_q, n_tick;
	logic [1:0] op_q, n_op;
	logic       run_q, n_run;
	logic [3:0] addr_q, n_addr;
	logic [7:0] data_q, n_data;
	logic [7:0] acc_q, n_acc;
	logic [3:0] pins_q, n_pins;
	logic       done;
	logic [7:0] plen;
	logic [2:0] last_phase;
	logic [1:0] last_slot;

	assign plen       = (plen_q == 8'd0) ? 8'd1 : plen_q;
	assign last_phase = (op_q == OP_READ) ? PH_SLOT : PH_RELEASE;
	assign last_slot  = (op_q == OP_KICK) ? SLOT_FIRST : SLOT_LAST;

	always_comb begin
		n_phase = phase_q;
		n_slot  = slot_q;
		n_tick  = tick_q;
		n_op    = op_q;
		n_run   = run_q;
		n_addr  = addr_q;
		n_data  = data_q;
		n_acc   = acc_q;
		n_pins  = pins_q;
		done    = 1'b0;
		if (!run_q) begin
			if (start_req && func != OP_RESERVED) begin
				n_op = func;
				if (func == OP_KICK) begin
					n_addr = ctl_q;
					n_data = {6'd0, segment};
				end else begin
					n_addr = address;
					n_data = write_data;
				end
				n_run   = 1'b1;
				n_phase = PH_STROBES_UP;
				n_slot  = SLOT_FIRST;
				n_pins  = enter_pins(PH_STROBES_UP, n_op, SLOT_FIRST, n_addr, n_data, pins_q);
				n_tick  = 8'd1;
			end
		end else if (tick_q < plen) begin
			n_tick = tick_q + 8'd1;
		end else if (phase_q >= last_phase) begin
			// return pair is sampled as the slot phase closes
			if (op_q == OP_READ)
				n_acc[{slot_q, 1'b0} +: 2] = {return_high, return_low};
			if (slot_q >= last_slot) begin
				n_run = 1'b0;
				done  = 1'b1;
			end else begin
				n_slot  = slot_q + 2'd1;
				n_phase = PH_STROBES_UP;
				n_pins  = enter_pins(PH_STROBES_UP, op_q, n_slot, addr_q, data_q, pins_q);
				n_tick  = 8'd1;
			end
		end else begin
			n_phase = phase_q + 3'd1;
			n_pins  = enter_pins(n_phase, op_q, slot_q, addr_q, data_q, pins_q);
			n_tick  = 8'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_STROBES_UP;
			slot_q  <= SLOT_FIRST;
			tick_q  <= 8'd0;
			op_q    <= OP_READ;
			run_q   <= 1'b0;
			addr_q  <= 4'd0;
			data_q  <= 8'd0;
			acc_q   <= 8'd0;
			pins_q  <= 4'd0;
		end else if (step) begin
			phase_q <= n_phase;
			slot_q  <= n_slot;
			tick_q  <= n_tick;
			op_q    <= n_op;
			run_q   <= n_run;
			addr_q  <= n_addr;
			data_q  <= n_data;
			acc_q   <= n_acc;
			pins_q  <= n_pins;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plen_q <= 8'd1;
			ctl_q  <= 4'd0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_PHASE_LENGTH:    plen_q <= cfg_data;
				CFG_CONTROL_ADDRESS: ctl_q  <= cfg_data[3:0];
				default:             plen_q <= plen_q;
			endcase
		end
	end

	assign res.line_high   = n_pins[3];
	assign res.line_low    = n_pins[2];
	assign res.strobe_zero = n_pins[1];
	assign res.strobe_one  = n_pins[0];
	assign res.busy_res    = n_run;
	assign res.done_res    = done;
	assign res.read_data   = n_acc;

endmodule

// ===== rtl/two_bit_strobe_bus_master.sv =====
// result: each input transfer's result is formed combinationally and registered in the output register
// throughput: one tick per cycle; the sequencer state and output register both
// advance on each input transfer, and a result held by the receiver stalls the
// input until it drains
// reset: arst_n clears the sequencer to idle with all pins low, phase_length
// to one and control_address to zero
// ----------------------------------------------------------------------------
// two_bit_strobe_bus_master
// tick-driven master for a two-line strobe bus, stream in and stream out
// ----------------------------------------------------------------------------
module two_bit_strobe_bus_master
	import tbsb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// start_req, address[3:0], write_data[7:0], segment[1:0], return_high,
	// return_low, zero fill
	input  logic [23:0] s_axis_tdata,
	// func[1:0]
	input  logic [1:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// line_high, line_low, strobe_zero, strobe_one, busy_res, done_res,
	// read_data[7:0], zero fill
	output logic [15:0] m_axis_tdata,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [7:0]  cfg_data
);

	logic step;
	res_t res;
	res_t res_q;
	logic out_valid_q;

	// room when the output register is empty or drains this cycle
	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign step          = s_axis_tvalid && s_axis_tready;

	tbsb_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (step),
		.start_req   (s_axis_tdata[0]),
		.func        (s_axis_tuser),
		.address     (s_axis_tdata[4:1]),
		.write_data  (s_axis_tdata[12:5]),
		.segment     (s_axis_tdata[14:13]),
		.return_high (s_axis_tdata[15]),
		.return_low  (s_axis_tdata[16]),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.res         (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step)
			res_q <= res;
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {2'b00, res_q.read_data, res_q.done_res, res_q.busy_res,
		res_q.strobe_one, res_q.strobe_zero, res_q.line_low, res_q.line_high};

endmodule

// ===== rtl/tbsb_chk.sv =====
// ----------------------------------------------------------------------------
// tbsb_chk
// port-level checks on the strobe bus master, bound to the top level
// ----------------------------------------------------------------------------
`include "two_bit_strobe_bus_master_macros.svh"

module tbsb_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [15:0] m_axis_tdata
);

	`TBSB_ASSERT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")
	`TBSB_ASSERT(a_in_to_out, clk, arst_n, s_axis_tvalid && s_axis_tready |=> m_axis_tvalid, "transfer gave no result")
	`TBSB_ASSERT(a_ready_empty, clk, arst_n, !m_axis_tvalid |-> s_axis_tready, "input stalled with empty output")
	`TBSB_ASSERT(a_done_idle, clk, arst_n, m_axis_tvalid |-> !(m_axis_tdata[4] && m_axis_tdata[5]), "done while busy")
	`TBSB_ASSERT_ALWAYS(a_fill_zero, clk, m_axis_tvalid |-> m_axis_tdata[15:14] == 2'b00, "fill bits set")

endmodule

bind two_bit_strobe_bus_master tbsb_chk u_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
